// ----- hw/rtl/dmx_pkg.sv -----
// Package for the DMX512 frame transmitter: phase codes, register indexes
// and the structs that travel between the core, the output queue and the top.
// No dependencies.
package dmx_pkg;

   localparam int unsigned DATA_BITS     = 8;
   localparam int unsigned BITS_PER_BYTE = 11;
   localparam int unsigned TICK_W        = 20;
   localparam int unsigned BITIDX_W      = 4;
   localparam int unsigned CSR_DATA_W    = 20;
   localparam int unsigned CSR_INDEX_W   = 2;

   localparam logic [15:0] BIT_TICKS_RESET   = 16'd288;
   localparam logic [19:0] BREAK_TICKS_RESET = 20'd7200;
   localparam logic [15:0] MAB_TICKS_RESET   = 16'd864;

   localparam logic [CSR_INDEX_W-1:0] REG_BIT_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BREAK_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAB_TICKS   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_BREAK = 3'd1,
      PH_MAB   = 3'd2,
      PH_WAIT  = 3'd3,
      PH_BITS  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [15:0] bit_ticks;
      logic [19:0] break_ticks;
      logic [15:0] mab_ticks;
   } dmx_cfg_type;

   typedef struct packed {
      logic       start_frame;
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       byte_last;
   } dmx_req_type;

   typedef struct packed {
      logic tx_line;
      logic byte_taken;
      logic busy_res;
      logic frame_done;
   } dmx_result_type;

endpackage

// ----- hw/rtl/dmx512_frame_transmitter_unit.sv -----
// Top level of the DMX512 frame transmitter: timing registers, line state
// machine and result queue. Depends on dmx_pkg, dmx_core and dmx_outq.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | start_frame, byte_valid, byte_value, byte_last
//   rsp     | out       | rsp_valid/stall  | tx_line, byte_taken, busy_res, frame_done
//   csr     | in        | csr_write_enable | csr_index, csr_write_data
//
// One item is one tick; an item is accepted every cycle while req_stall is low
// and its result is registered in the result register, or in its skid entry.
// The core is a single registered step.
// req_stall rises only when both the result register and its skid entry hold
// items, and comes from a flip-flop. Synchronous reset idles the line state
// and restores the default tick counts.
module dmx512_frame_transmitter_unit
   import dmx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_frame,
   input  logic                   req_byte_valid,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_byte_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_tx_line,
   output logic                   rsp_byte_taken,
   output logic                   rsp_busy_res,
   output logic                   rsp_frame_done,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   dmx_cfg_type    cfg_ff;
   dmx_req_type    req;
   dmx_result_type core_result;
   dmx_result_type rsp_data;
   logic           accept;
   logic           queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks   <= BIT_TICKS_RESET;
         cfg_ff.break_ticks <= BREAK_TICKS_RESET;
         cfg_ff.mab_ticks   <= MAB_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BIT_TICKS:   cfg_ff.bit_ticks   <= csr_write_data[15:0];
            REG_BREAK_TICKS: cfg_ff.break_ticks <= csr_write_data;
            REG_MAB_TICKS:   cfg_ff.mab_ticks   <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req.start_frame = req_start_frame;
   assign req.byte_valid  = req_byte_valid;
   assign req.byte_value  = req_byte_value;
   assign req.byte_last   = req_byte_last;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   dmx_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   dmx_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_tx_line    = rsp_data.tx_line;
   assign rsp_byte_taken = rsp_data.byte_taken;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_frame_done = rsp_data.frame_done;

endmodule

// ----- hw/rtl/dmx_core.sv -----
// Line timing state machine: one accepted item advances the frame by one tick
// and yields that tick's result. Depends on dmx_pkg.
module dmx_core
   import dmx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  dmx_req_type    req,
   input  dmx_cfg_type    cfg,
   output dmx_result_type result
);

   phase_type             phase_ff, phase_in, phase_mid;
   logic [TICK_W-1:0]     tick_ff, tick_in, tick_mid, tick_inc, dur;
   logic [BITIDX_W-1:0]   bit_index_ff, bit_index_in, bit_index_mid, bit_index_inc;
   logic [BITIDX_W-1:0]   data_pos;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic                  final_ff, final_in;
   logic                  taken;
   logic                  count_done;
   logic                  done;

   // Entry step: a frame request or a byte take happens on the same tick.
   always_comb begin
      phase_mid     = phase_ff;
      tick_mid      = tick_ff;
      bit_index_mid = bit_index_ff;
      shift_in      = shift_ff;
      final_in      = final_ff;
      taken         = 1'b0;
      if (phase_ff == PH_IDLE && req.start_frame) begin
         phase_mid = PH_BREAK;
         tick_mid  = '0;
      end else if (phase_ff == PH_WAIT && req.byte_valid) begin
         shift_in      = req.byte_value;
         final_in      = req.byte_last;
         bit_index_mid = '0;
         tick_mid      = '0;
         phase_mid     = PH_BITS;
         taken         = 1'b1;
      end
   end

   always_comb begin
      case (phase_mid)
         PH_BREAK: dur = cfg.break_ticks;
         PH_MAB:   dur = {{(TICK_W-16){1'b0}}, cfg.mab_ticks};
         PH_BITS:  dur = {{(TICK_W-16){1'b0}}, cfg.bit_ticks};
         default:  dur = '0;
      endcase
   end

   // A duration of zero still finishes after one tick since the compare
   // is against the incremented count.
   assign tick_inc      = tick_mid + 1'b1;
   assign count_done    = (tick_inc >= dur);
   assign bit_index_inc = bit_index_mid + 1'b1;

   // Next state.
   always_comb begin
      phase_in     = phase_mid;
      tick_in      = tick_mid;
      bit_index_in = bit_index_mid;
      done         = 1'b0;
      case (phase_mid)
         PH_BREAK, PH_MAB: begin
            tick_in = count_done ? '0 : tick_inc;
            if (count_done) begin
               phase_in = (phase_mid == PH_BREAK) ? PH_MAB : PH_WAIT;
            end
         end
         PH_BITS: begin
            tick_in = count_done ? '0 : tick_inc;
            if (count_done) begin
               bit_index_in = bit_index_inc;
               if (bit_index_inc >= BITIDX_W'(BITS_PER_BYTE)) begin
                  bit_index_in = '0;
                  if (final_in) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign data_pos = bit_index_mid - 1'b1;

   // Outputs for this tick.
   always_comb begin
      result.byte_taken = taken;
      result.frame_done = done;
      result.busy_res   = (phase_mid != PH_IDLE);
      case (phase_mid)
         PH_BREAK: result.tx_line = 1'b0;
         PH_BITS: begin
            if (bit_index_mid == '0) begin
               result.tx_line = 1'b0;
            end else if (bit_index_mid <= BITIDX_W'(DATA_BITS)) begin
               result.tx_line = shift_in[data_pos[2:0]];
            end else begin
               result.tx_line = 1'b1;
            end
         end
         default: result.tx_line = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         final_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         final_ff     <= final_in;
      end
   end

endmodule

// ----- hw/rtl/dmx_outq.sv -----
// Result register with a skid entry behind it, so the input side's stall is
// a registered signal. Depends on dmx_pkg.
module dmx_outq
   import dmx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  dmx_result_type push_data,
   output logic           full,
   output logic           out_valid,
   input  logic           out_stall,
   output dmx_result_type out_data
);

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   dmx_result_type main_ff, main_in;
   dmx_result_type skid_ff, skid_in;
   logic           pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         main_valid_in = skid_valid_ff;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      // A push only happens while the skid entry is empty.
      if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ----- hw/rtl/dmx_checker.sv -----
// Port-level checks on the DMX512 frame transmitter, bound to its top level.
// Depends on dmx_pkg and dmx512_frame_transmitter_unit.
module dmx_checker
   import dmx_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_tx_line,
   input logic rsp_byte_taken,
   input logic rsp_busy_res,
   input logic rsp_frame_done
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_line)
         && $stable(rsp_byte_taken) && $stable(rsp_busy_res) && $stable(rsp_frame_done))
      else $error("stalled result changed");

   // The last stop bit only ends inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_busy_res && rsp_tx_line && !rsp_byte_taken)
      else $error("frame_done outside a stop bit");

   // A byte taken starts its start bit on the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_taken |-> rsp_busy_res && !rsp_tx_line)
      else $error("taken byte without a low start bit");

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dmx512_frame_transmitter_unit dmx_checker u_dmx_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_tx_line    (rsp_tx_line),
   .rsp_byte_taken (rsp_byte_taken),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_frame_done (rsp_frame_done)
);
